[design/iafl_pkg.sv]
// Shared types, widths and codes of the free-list index allocator.
package iafl_pkg;

    // Field widths of the request and result items.
    localparam int OP_W      = 1;
    localparam int LIMIT_W   = 13;
    localparam int INDEX_W   = 12;
    localparam int CAP_W     = 13;
    localparam int BUMP_W    = 13;
    localparam int STATUS_W  = 3;

    // Stream word widths; the data words are padded to whole bytes.
    localparam int S_TDATA_W = 32;
    localparam int S_TUSER_W = OP_W;
    localparam int M_TDATA_W = 16;
    localparam int M_TUSER_W = 1 + STATUS_W;

    // Default store depth and register reset value.
    localparam int SLOTS_DEFAULT = 4096;
    localparam logic [CAP_W-1:0] CAP_RESET = 13'd4096;

    // Request kinds.
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_REUSED     = 3'd0,
        ST_NEW        = 3'd1,
        ST_ALLOC_FAIL = 3'd2,
        ST_FREED      = 3'd3,
        ST_IGNORED    = 3'd4,
        ST_DROPPED    = 3'd5
    } status_t;

    // Controller states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_SEARCH,
        S_SHIFT,
        S_RESULT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic free_exec;
        logic search_init;
        logic search_step;
        logic shift_init;
        logic shift_step;
        logic shift_done;
        logic bump_exec;
        logic publish;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_free;
        logic search_hit;
        logic search_more;
        logic shift_more;
        logic out_free;
    } dp_status_t;

endpackage

[design/iafl_dp.sv]
// Datapath of the allocator: freed stack, counters, search and compaction pointers, results.
module iafl_dp #(
    parameter int SLOTS = iafl_pkg::SLOTS_DEFAULT
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic [iafl_pkg::CAP_W-1:0]   cfg_wr_data,
    input  logic                         in_op,
    input  logic [iafl_pkg::LIMIT_W-1:0] in_limit,
    input  logic [iafl_pkg::INDEX_W-1:0] in_ret_index,
    input  iafl_pkg::ctrl_cmd_t          cmd,
    output iafl_pkg::dp_status_t         st,
    input  logic                         out_ready,
    output logic                         out_valid,
    output logic                         out_ok,
    output logic [iafl_pkg::INDEX_W-1:0] out_slot,
    output iafl_pkg::status_t            out_status
);

    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);
    localparam logic [31:0] SLOTS_U = 32'(SLOTS);

    // Freed stack storage and its ports.
    logic [iafl_pkg::INDEX_W-1:0] stack_mem [SLOTS];
    logic [iafl_pkg::INDEX_W-1:0] rd_data_reg;
    logic [AW-1:0]                rd_addr;
    logic                         mem_we;
    logic [AW-1:0]                mem_waddr;
    logic [iafl_pkg::INDEX_W-1:0] mem_wdata;

    // Control registers.
    logic [CW-1:0]                count_reg, count_next;
    logic [iafl_pkg::BUMP_W-1:0]  bump_reg, bump_next;
    logic [iafl_pkg::CAP_W-1:0]   cap_reg, cap_next;
    logic [CW-1:0]                ptr_reg, ptr_next;
    logic                         rd_valid_reg, rd_valid_next;
    logic                         wr_pend_reg, wr_pend_next;
    logic                         out_valid_reg, out_valid_next;

    // Payload registers.
    logic                         op_reg, op_next;
    logic [iafl_pkg::LIMIT_W-1:0] limit_reg, limit_next;
    logic [iafl_pkg::INDEX_W-1:0] fidx_reg, fidx_next;
    logic [AW-1:0]                rd_k_reg, rd_k_next;
    logic [AW-1:0]                wr_addr_reg, wr_addr_next;
    logic                         res_ok_reg, res_ok_next;
    logic [iafl_pkg::INDEX_W-1:0] res_slot_reg, res_slot_next;
    iafl_pkg::status_t            res_status_reg, res_status_next;
    logic                         out_ok_reg, out_ok_next;
    logic [iafl_pkg::INDEX_W-1:0] out_slot_reg, out_slot_next;
    iafl_pkg::status_t            out_status_reg, out_status_next;

    // Derived values.
    logic [CW-1:0] ptr_dec;
    logic [CW:0]   ptr_inc;
    logic          free_ignored;
    logic          stack_full;
    logic          bump_ok;

    assign ptr_dec      = ptr_reg - CW'(1);
    assign ptr_inc      = {1'b0, ptr_reg} + (CW + 1)'(1);
    assign free_ignored = {1'b0, fidx_reg} >= bump_reg;
    assign stack_full   = count_reg == CW'(SLOTS);
    assign bump_ok      = (bump_reg < cap_reg) && (32'(bump_reg) < SLOTS_U)
                          && (bump_reg < limit_reg);

    // Status towards the controller.
    assign st.is_free     = op_reg == iafl_pkg::OP_FREE;
    assign st.search_hit  = rd_valid_reg && ({1'b0, rd_data_reg} < limit_reg);
    assign st.search_more = ptr_reg != '0;
    assign st.shift_more  = ptr_inc < {1'b0, count_reg};
    assign st.out_free    = !out_valid_reg || out_ready;

    // Read address: upward while compacting, downward while searching.
    assign rd_addr = cmd.shift_step ? ptr_inc[AW-1:0] : ptr_dec[AW-1:0];

    // Write port: a push on free, or one moved entry while compacting.
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = wr_addr_reg;
        mem_wdata = rd_data_reg;
        if (wr_pend_reg) begin
            mem_we = 1'b1;
        end else if (cmd.free_exec && !free_ignored && !stack_full) begin
            mem_we    = 1'b1;
            mem_waddr = count_reg[AW-1:0];
            mem_wdata = fidx_reg;
        end
    end

    // Memory with registered read data.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            stack_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= stack_mem[rd_addr];
    end

    // Next-state logic of all registers, driven by the controller's commands.
    always_comb begin
        count_next      = count_reg;
        bump_next       = bump_reg;
        cap_next        = cap_reg;
        ptr_next        = ptr_reg;
        rd_valid_next   = cmd.search_step;
        wr_pend_next    = cmd.shift_step;
        out_valid_next  = out_valid_reg && !out_ready;
        op_next         = op_reg;
        limit_next      = limit_reg;
        fidx_next       = fidx_reg;
        rd_k_next       = rd_k_reg;
        wr_addr_next    = wr_addr_reg;
        res_ok_next     = res_ok_reg;
        res_slot_next   = res_slot_reg;
        res_status_next = res_status_reg;
        out_ok_next     = out_ok_reg;
        out_slot_next   = out_slot_reg;
        out_status_next = out_status_reg;

        if (cfg_wr_en) begin
            cap_next = cfg_wr_data;
        end

        // Capture the accepted request item.
        if (cmd.load) begin
            op_next    = in_op;
            limit_next = in_limit;
            fidx_next  = in_ret_index;
        end

        // Free: push onto the stack unless never handed out or stack full.
        if (cmd.free_exec) begin
            res_slot_next = '0;
            if (free_ignored) begin
                res_ok_next     = 1'b0;
                res_status_next = iafl_pkg::ST_IGNORED;
            end else if (stack_full) begin
                res_ok_next     = 1'b0;
                res_status_next = iafl_pkg::ST_DROPPED;
            end else begin
                res_ok_next     = 1'b1;
                res_status_next = iafl_pkg::ST_FREED;
                count_next      = count_reg + CW'(1);
            end
        end

        // Search from the newest entry down, one read per cycle.
        if (cmd.search_init) begin
            ptr_next = count_reg;
        end
        if (cmd.search_step) begin
            ptr_next  = ptr_dec;
            rd_k_next = ptr_dec[AW-1:0];
        end

        // A hit: take the entry and start closing the gap from its place.
        if (cmd.shift_init) begin
            ptr_next        = CW'(rd_k_reg);
            res_ok_next     = 1'b1;
            res_slot_next   = rd_data_reg;
            res_status_next = iafl_pkg::ST_REUSED;
        end
        if (cmd.shift_step) begin
            wr_addr_next = ptr_reg[AW-1:0];
            ptr_next     = ptr_inc[CW-1:0];
        end
        if (cmd.shift_done) begin
            count_next = count_reg - CW'(1);
        end

        // No freed index fits: try the bump counter.
        if (cmd.bump_exec) begin
            if (bump_ok) begin
                res_ok_next     = 1'b1;
                res_slot_next   = bump_reg[iafl_pkg::INDEX_W-1:0];
                res_status_next = iafl_pkg::ST_NEW;
                bump_next       = bump_reg + iafl_pkg::BUMP_W'(1);
            end else begin
                res_ok_next     = 1'b0;
                res_slot_next   = '0;
                res_status_next = iafl_pkg::ST_ALLOC_FAIL;
            end
        end

        // Hand the result over to the output register.
        if (cmd.publish) begin
            out_valid_next  = 1'b1;
            out_ok_next     = res_ok_reg;
            out_slot_next   = res_slot_reg;
            out_status_next = res_status_reg;
        end
    end

    // Control registers with reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            bump_reg      <= '0;
            cap_reg       <= iafl_pkg::CAP_RESET;
            ptr_reg       <= '0;
            rd_valid_reg  <= 1'b0;
            wr_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            count_reg     <= count_next;
            bump_reg      <= bump_next;
            cap_reg       <= cap_next;
            ptr_reg       <= ptr_next;
            rd_valid_reg  <= rd_valid_next;
            wr_pend_reg   <= wr_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        op_reg         <= op_next;
        limit_reg      <= limit_next;
        fidx_reg       <= fidx_next;
        rd_k_reg       <= rd_k_next;
        wr_addr_reg    <= wr_addr_next;
        res_ok_reg     <= res_ok_next;
        res_slot_reg   <= res_slot_next;
        res_status_reg <= res_status_next;
        out_ok_reg     <= out_ok_next;
        out_slot_reg   <= out_slot_next;
        out_status_reg <= out_status_next;
    end

    assign out_valid  = out_valid_reg;
    assign out_ok     = out_ok_reg;
    assign out_slot   = out_slot_reg;
    assign out_status = out_status_reg;

endmodule

[design/iafl_ctrl.sv]
// Controller state machine of the allocator: sequences free, search, compaction and result hand-over.
module iafl_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  iafl_pkg::dp_status_t st,
    output iafl_pkg::ctrl_cmd_t  cmd
);

    iafl_pkg::state_t state_reg, state_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= iafl_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            iafl_pkg::S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = iafl_pkg::S_DISPATCH;
                end
            end
            iafl_pkg::S_DISPATCH: begin
                if (st.is_free) begin
                    cmd.free_exec = 1'b1;
                    state_next    = iafl_pkg::S_RESULT;
                end else begin
                    cmd.search_init = 1'b1;
                    state_next      = iafl_pkg::S_SEARCH;
                end
            end
            iafl_pkg::S_SEARCH: begin
                if (st.search_hit) begin
                    cmd.shift_init = 1'b1;
                    state_next     = iafl_pkg::S_SHIFT;
                end else if (st.search_more) begin
                    cmd.search_step = 1'b1;
                end else begin
                    cmd.bump_exec = 1'b1;
                    state_next    = iafl_pkg::S_RESULT;
                end
            end
            iafl_pkg::S_SHIFT: begin
                if (st.shift_more) begin
                    cmd.shift_step = 1'b1;
                end else begin
                    cmd.shift_done = 1'b1;
                    state_next     = iafl_pkg::S_RESULT;
                end
            end
            iafl_pkg::S_RESULT: begin
                if (st.out_free) begin
                    cmd.publish = 1'b1;
                    state_next  = iafl_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = iafl_pkg::S_IDLE;
            end
        endcase
    end

endmodule

[design/index_allocator_free_list_top.sv]
// Top level of the free-list index allocator: stream ports, controller and datapath.
//
// Requests arrive on the s_ channel, one item each: allocate (with a limit) or
// free (with an index). Every request gives exactly one result item on the m_
// channel. The capacity register is written through cfg_wr_en/cfg_wr_data; the
// user must write it only while the block is idle: the block does not enforce it.
// A free is dispatched, pushed or refused, and its result then moves to the output
// register. An allocate that reuses a freed index examines freed entries from
// the top of the stack (one memory read per cycle), then moves each newer entry
// down one place to close the gap (one per cycle through the single write port).
// An allocate that finds no fitting freed index, whether it gets a new slot or
// fails, searches the whole stack of depth D. One request is processed at a time;
// the next request is taken the cycle after the previous result enters the output
// register. If the receiver stalls, the next result waits in the block and the
// input is held off until the output register empties.
// After reset the capacity is 4096, the stack is empty and the bump counter
// is zero; the stack memory needs no clearing.
module index_allocator_free_list_top #(
    parameter int SLOTS = iafl_pkg::SLOTS_DEFAULT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Capacity register write.
    input  logic                           cfg_wr_en,
    input  logic [iafl_pkg::CAP_W-1:0]     cfg_wr_data,
    // Request items.
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [iafl_pkg::S_TDATA_W-1:0] s_tdata,  // limit[12:0], ret_index[24:13], zeros
    input  logic [iafl_pkg::S_TUSER_W-1:0] s_tuser,  // op[0]
    // Result items.
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [iafl_pkg::M_TDATA_W-1:0] m_tdata,  // slot[11:0], zeros
    output logic [iafl_pkg::M_TUSER_W-1:0] m_tuser   // ok[0], status[3:1]
);

    iafl_pkg::ctrl_cmd_t          cmd;
    iafl_pkg::dp_status_t         st;
    logic                         out_ok;
    logic [iafl_pkg::INDEX_W-1:0] out_slot;
    iafl_pkg::status_t            out_status;

    // Sequencer.
    iafl_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    // Stack, counters and result registers.
    iafl_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .in_op         (s_tuser[0]),
        .in_limit      (s_tdata[iafl_pkg::LIMIT_W-1:0]),
        .in_ret_index  (s_tdata[iafl_pkg::LIMIT_W +: iafl_pkg::INDEX_W]),
        .cmd           (cmd),
        .st            (st),
        .out_ready     (m_tready),
        .out_valid     (m_tvalid),
        .out_ok        (out_ok),
        .out_slot      (out_slot),
        .out_status    (out_status)
    );

    // Pack the result item.
    assign m_tdata = {{(iafl_pkg::M_TDATA_W - iafl_pkg::INDEX_W){1'b0}}, out_slot};
    assign m_tuser = {out_status, out_ok};

endmodule
